// ===== hw/rtl/ggl_pkg.sv =====
// ============================================================================
// ggl_pkg: garage gate light controller package
// Shared types, register map codes and timer helpers.
// ============================================================================
`default_nettype none

package ggl_pkg;

    // Width of the time base used for all timer differences
    localparam int TIME_WIDTH = 16;
    // Compare width wide enough for both a time difference and a register
    localparam int CMP_WIDTH  = (TIME_WIDTH > 16) ? TIME_WIDTH : 16;
    localparam int ADDR_WIDTH = 4;

    typedef logic [TIME_WIDTH-1:0] t_time;

    // Register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_OPERATE = 2'd0;
    localparam logic [1:0] REG_BARRIER = 2'd1;
    localparam logic [1:0] REG_BLINK   = 2'd2;
    localparam logic [1:0] REG_SETTLE  = 2'd3;

    localparam logic [15:0] OPERATE_RESET = 16'd5000;
    localparam logic [15:0] BARRIER_RESET = 16'd10000;
    localparam logic [15:0] BLINK_RESET   = 16'd1000;
    localparam logic [15:0] SETTLE_RESET  = 16'd0;

    // Mode codes reported on mode_now
    localparam logic [2:0] CODE_IDLE  = 3'd0;
    localparam logic [2:0] CODE_ENTRY = 3'd1;
    localparam logic [2:0] CODE_EXIT  = 3'd2;
    localparam logic [2:0] CODE_INTR  = 3'd3;
    localparam logic [2:0] CODE_FAULT = 3'd4;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_ENTRY = 5'b00010,
        S_EXIT  = 5'b00100,
        S_INTR  = 5'b01000,
        S_FAULT = 5'b10000
    } t_mode;

    typedef struct packed {
        logic [15:0] operate_timeout;
        logic [15:0] barrier_timeout;
        logic [15:0] blink_period;
        logic [15:0] settle;
    } t_cfg;

    typedef struct packed {
        logic        barrier_clear;
        logic        entry_button;
        logic        exit_button;
        logic [15:0] time_ms;
    } t_sample;

    typedef struct packed {
        logic gate;
        logic exit_green;
        logic exit_red;
        logic entry_green;
        logic entry_red;
    } t_lights;

    typedef struct packed {
        t_lights    lights;
        logic [2:0] mode_now;
    } t_result;

    // Bring the 16-bit sample time onto the internal time base
    function automatic t_time to_time(input logic [15:0] x);
        logic [CMP_WIDTH-1:0] w;
        w = CMP_WIDTH'(x);
        return w[TIME_WIDTH-1:0];
    endfunction

    // Elapsed-time check: difference >= register value
    function automatic logic time_ge(input t_time diff, input logic [15:0] lim);
        return CMP_WIDTH'(diff) >= CMP_WIDTH'(lim);
    endfunction

    function automatic logic [2:0] mode_code(input t_mode m);
        logic [2:0] c;
        case (m)
            S_ENTRY: c = CODE_ENTRY;
            S_EXIT:  c = CODE_EXIT;
            S_INTR:  c = CODE_INTR;
            S_FAULT: c = CODE_FAULT;
            default: c = CODE_IDLE;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ggl_cfg.sv =====
// ============================================================================
// ggl_cfg: configuration registers
// APB-style register file holding the four timer settings.
// ============================================================================
`default_nettype none

module ggl_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ggl_pkg::ADDR_WIDTH-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    output ggl_pkg::t_cfg                  o_cfg
);

    ggl_pkg::t_cfg r_cfg;
    ggl_pkg::t_cfg n_cfg;
    logic          wr_en;
    logic [1:0]    reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    // Decode the write transaction
    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            case (reg_idx)
                ggl_pkg::REG_OPERATE: n_cfg.operate_timeout = pwdata[15:0];
                ggl_pkg::REG_BARRIER: n_cfg.barrier_timeout = pwdata[15:0];
                ggl_pkg::REG_BLINK:   n_cfg.blink_period    = pwdata[15:0];
                ggl_pkg::REG_SETTLE:  n_cfg.settle          = pwdata[15:0];
                default:              n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.operate_timeout <= ggl_pkg::OPERATE_RESET;
            r_cfg.barrier_timeout <= ggl_pkg::BARRIER_RESET;
            r_cfg.blink_period    <= ggl_pkg::BLINK_RESET;
            r_cfg.settle          <= ggl_pkg::SETTLE_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Read back the selected register
    always_comb begin
        case (reg_idx)
            ggl_pkg::REG_OPERATE: prdata = {16'd0, r_cfg.operate_timeout};
            ggl_pkg::REG_BARRIER: prdata = {16'd0, r_cfg.barrier_timeout};
            ggl_pkg::REG_BLINK:   prdata = {16'd0, r_cfg.blink_period};
            ggl_pkg::REG_SETTLE:  prdata = {16'd0, r_cfg.settle};
            default:              prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== hw/rtl/ggl_core.sv =====
// ============================================================================
// ggl_core: controller state and step logic
// Holds mode, timer start marks and held lights; computes one step per cycle while i_step is high.
// ============================================================================
`default_nettype none

module ggl_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  ggl_pkg::t_sample i_sample,
    input  ggl_pkg::t_cfg    i_cfg,
    output ggl_pkg::t_result o_result
);

    ggl_pkg::t_mode   r_mode,   n_mode;
    ggl_pkg::t_time   r_op_start,  n_op_start;
    ggl_pkg::t_time   r_bar_start, n_bar_start;
    ggl_pkg::t_time   r_blk_start, n_blk_start;
    ggl_pkg::t_lights r_held,   n_held;

    ggl_pkg::t_time   t_now;
    ggl_pkg::t_time   d_op, d_bar, d_blk, d_phase;
    logic [15:0]      half_period;
    ggl_pkg::t_lights lights;

    assign t_now       = ggl_pkg::to_time(i_sample.time_ms);
    assign d_op        = t_now - r_op_start;
    assign d_bar       = t_now - r_bar_start;
    assign d_blk       = t_now - r_blk_start;
    assign half_period = {1'b0, i_cfg.blink_period[15:1]};

    // Next state, timer marks and lights for one sample
    always_comb begin
        n_mode      = r_mode;
        n_op_start  = r_op_start;
        n_bar_start = r_bar_start;
        n_blk_start = t_now;
        d_phase     = d_blk;
        lights      = r_held;
        case (r_mode)
            ggl_pkg::S_ENTRY, ggl_pkg::S_EXIT: begin
                lights = '0;
                if (r_mode == ggl_pkg::S_ENTRY) begin
                    lights.entry_green = 1'b1;
                    lights.exit_red    = 1'b1;
                end else begin
                    lights.entry_red  = 1'b1;
                    lights.exit_green = 1'b1;
                end
                if (ggl_pkg::time_ge(d_op, i_cfg.operate_timeout)) begin
                    n_mode = ggl_pkg::S_IDLE;
                end
                // Broken beam overrides the timeout
                if (!i_sample.barrier_clear) begin
                    n_mode      = ggl_pkg::S_INTR;
                    n_bar_start = t_now;
                end
            end
            ggl_pkg::S_INTR: begin
                if (i_sample.barrier_clear && ggl_pkg::time_ge(d_bar, i_cfg.settle)) begin
                    n_mode = ggl_pkg::S_IDLE;
                end
                if (ggl_pkg::time_ge(d_bar, i_cfg.barrier_timeout)) begin
                    n_mode = ggl_pkg::S_FAULT;
                end
            end
            ggl_pkg::S_FAULT: begin
                lights = '0;
                // Restart the blink period once it has run out
                if (ggl_pkg::time_ge(d_blk, i_cfg.blink_period)) begin
                    n_blk_start = t_now;
                    d_phase     = '0;
                end else begin
                    n_blk_start = r_blk_start;
                end
                if (ggl_pkg::time_ge(d_phase, half_period)) begin
                    lights.entry_red = 1'b1;
                    lights.exit_red  = 1'b1;
                end else begin
                    lights.entry_green = 1'b1;
                    lights.exit_green  = 1'b1;
                end
                if (i_sample.barrier_clear) begin
                    n_mode = ggl_pkg::S_IDLE;
                end
            end
            default: begin
                lights           = '0;
                lights.entry_red = 1'b1;
                lights.exit_red  = 1'b1;
                lights.gate      = 1'b1;
                n_mode           = ggl_pkg::S_IDLE;
                if (i_sample.entry_button) begin
                    n_mode     = ggl_pkg::S_ENTRY;
                    n_op_start = t_now;
                end
                // Exit wins over entry
                if (i_sample.exit_button) begin
                    n_mode     = ggl_pkg::S_EXIT;
                    n_op_start = t_now;
                end
            end
        endcase
        n_held = lights;
    end

    // Commit the step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= ggl_pkg::S_IDLE;
            r_op_start  <= '0;
            r_bar_start <= '0;
            r_blk_start <= '0;
            r_held      <= '0;
        end else if (i_step) begin
            r_mode      <= n_mode;
            r_op_start  <= n_op_start;
            r_bar_start <= n_bar_start;
            r_blk_start <= n_blk_start;
            r_held      <= n_held;
        end
    end

    assign o_result.lights   = lights;
    assign o_result.mode_now = ggl_pkg::mode_code(n_mode);

endmodule

`default_nettype wire

// ===== hw/rtl/garage_gate_light_controller_unit.sv =====
// ============================================================================
// garage_gate_light_controller_unit: garage gate light controller
// Samples barrier, buttons and time; drives entry/exit and gate lights.
// ============================================================================
//  channel  | handshake                      | payload
//  ---------+--------------------------------+-----------------------------------
//  input    | i_in_valid / o_in_stall        | barrier_clear, buttons, time_ms
//  output   | o_out_valid / i_out_stall      | five lights, mode_now
//  config   | psel/penable/pwrite, pready=1  | paddr[3:2] index, pwdata[15:0]
//
//  One sample per cycle unless a held result stalls the pipe: input register,
//  one step of logic, result register. o_out_valid rises once an accepted
//  sample has been stepped from the input register into the result register.
//  Synchronous active-low reset: idle mode, timers zero, held lights off,
//  defaults loaded into the registers.
//  A stalled result holds the pipe; the input register still takes one sample.
`default_nettype none

module garage_gate_light_controller_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input channel
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_barrier_clear,
    input  logic                           i_entry_button,
    input  logic                           i_exit_button,
    input  logic [15:0]                    i_time_ms,
    // output channel
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_entry_red,
    output logic                           o_entry_green,
    output logic                           o_exit_red,
    output logic                           o_exit_green,
    output logic                           o_gate_light,
    output logic [2:0]                     o_mode_now,
    // configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ggl_pkg::ADDR_WIDTH-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    ggl_pkg::t_cfg    cfg;
    ggl_pkg::t_sample r_in;
    logic             r_in_valid, n_in_valid;
    ggl_pkg::t_result r_out, core_res;
    logic             r_out_valid, n_out_valid;
    logic             in_accept;
    logic             step;

    ggl_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Advance when the result register is free or being taken
    assign step       = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && r_out_valid && i_out_stall;
    assign in_accept  = i_in_valid && !o_in_stall;

    ggl_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_sample (r_in),
        .i_cfg    (cfg),
        .o_result (core_res)
    );

    // Input register
    always_comb begin
        n_in_valid = r_in_valid;
        if (in_accept) begin
            n_in_valid = 1'b1;
        end else if (step) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in.barrier_clear <= i_barrier_clear;
            r_in.entry_button  <= i_entry_button;
            r_in.exit_button   <= i_exit_button;
            r_in.time_ms       <= i_time_ms;
        end
    end

    // Result register
    always_comb begin
        n_out_valid = r_out_valid;
        if (step) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= core_res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_entry_red   = r_out.lights.entry_red;
    assign o_entry_green = r_out.lights.entry_green;
    assign o_exit_red    = r_out.lights.exit_red;
    assign o_exit_green  = r_out.lights.exit_green;
    assign o_gate_light  = r_out.lights.gate;
    assign o_mode_now    = r_out.mode_now;

`ifndef ASSERT_OFF
    // Input side stalls only behind a held result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && o_out_valid && i_out_stall))
        else $error("input stalled without a held result");

    // Gate light only with both reds and no greens
    a_gate_lights: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_gate_light) |->
        (o_entry_red && o_exit_red && !o_entry_green && !o_exit_green))
        else $error("gate light with inconsistent signal lights");

    // Never red and green together on one side
    a_side_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (!(o_entry_red && o_entry_green) && !(o_exit_red && o_exit_green)))
        else $error("red and green lit together");

    // A taken result with no pending sample leaves the output empty
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !r_in_valid) |=> !o_out_valid)
        else $error("result repeated after transaction");
`endif

endmodule

`default_nettype wire

// ===== tb/garage_gate_light_controller_unit_tb.sv =====
// ----------------------------------------------------------------------------
// garage_gate_light_controller_unit_tb: light controller self-checking bench
// Drives barrier/button/time samples through the valid/stall input channel,
// predicts the lights and mode of every transaction with a cycle-free model,
// and checks each result in order. Timing registers are rewritten through
// the APB port between phases, extremes included. Both channels idle at
// random, and one phase holds the output long enough to back up the input.
// ----------------------------------------------------------------------------
`default_nettype none

module garage_gate_light_controller_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ggl_pkg::*;

    localparam int STUCK_LIMIT = 3000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic                  i_barrier_clear = 1'b0;
    logic                  i_entry_button = 1'b0;
    logic                  i_exit_button = 1'b0;
    logic [15:0]           i_time_ms = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic                  o_entry_red;
    logic                  o_entry_green;
    logic                  o_exit_red;
    logic                  o_exit_green;
    logic                  o_gate_light;
    logic [2:0]            o_mode_now;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [ADDR_WIDTH-1:0] paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;

    garage_gate_light_controller_unit dut (.*);

    always #1 i_clk = ~i_clk;

    // Controller state as the bench sees it
    logic [2:0]  ctl_mode = CODE_IDLE;
    t_time       operate_t0 = '0;
    t_time       barrier_t0 = '0;
    t_time       blink_t0 = '0;
    t_lights     lights_held = '0;
    logic [15:0] operate_limit = OPERATE_RESET;
    logic [15:0] barrier_limit = BARRIER_RESET;
    logic [15:0] blink_period = BLINK_RESET;
    logic [15:0] settle_time = SETTLE_RESET;

    t_result     pending_lights[$];
    logic [15:0] last_time = '0;
    int          mismatches = 0;
    bit          send_gaps = 1'b0;
    bit          sink_stalls = 1'b0;
    int          sink_hold_cycles = 0;

    // Wrapped elapsed time against a 16-bit limit
    function automatic bit elapsed(t_time now, t_time since, logic [15:0] lim);
        t_time d;
        d = now - since;
        return longint'(d) >= longint'(lim);
    endfunction

    // Advance the controller by one sample and return its outputs
    function automatic t_result step_controller(logic clr, logic ent, logic ext,
                                                logic [15:0] tin);
        t_time      t;
        t_lights    lt;
        logic [2:0] nxt;
        t_result    r;
        t = t_time'(tin);
        lt = lights_held;
        nxt = ctl_mode;
        case (ctl_mode)
            CODE_ENTRY, CODE_EXIT: begin
                lt = '0;
                if (ctl_mode == CODE_ENTRY) begin
                    lt.entry_green = 1'b1;
                    lt.exit_red = 1'b1;
                end else begin
                    lt.entry_red = 1'b1;
                    lt.exit_green = 1'b1;
                end
                if (elapsed(t, operate_t0, operate_limit)) nxt = CODE_IDLE;
                // a broken beam beats the timeout
                if (!clr) begin
                    nxt = CODE_INTR;
                    barrier_t0 = t;
                end
            end
            CODE_INTR: begin
                if (clr && elapsed(t, barrier_t0, settle_time)) nxt = CODE_IDLE;
                if (elapsed(t, barrier_t0, barrier_limit)) nxt = CODE_FAULT;
            end
            CODE_FAULT: begin
                lt = '0;
                if (clr) nxt = CODE_IDLE;
            end
            default: begin
                lt = '0;
                lt.entry_red = 1'b1;
                lt.exit_red = 1'b1;
                lt.gate = 1'b1;
                nxt = CODE_IDLE;
                if (ent) begin
                    nxt = CODE_ENTRY;
                    operate_t0 = t;
                end
                // exit wins over entry
                if (ext) begin
                    nxt = CODE_EXIT;
                    operate_t0 = t;
                end
            end
        endcase
        // Blink: restart each full period, reds in the second half
        if (ctl_mode == CODE_FAULT) begin
            if (elapsed(t, blink_t0, blink_period)) blink_t0 = t;
            if (elapsed(t, blink_t0, blink_period >> 1)) begin
                lt.entry_red = 1'b1;
                lt.exit_red = 1'b1;
            end else begin
                lt.entry_green = 1'b1;
                lt.exit_green = 1'b1;
            end
        end else begin
            blink_t0 = t;
        end
        lights_held = lt;
        ctl_mode = nxt;
        r.lights = lt;
        r.mode_now = nxt;
        return r;
    endfunction

    function automatic void check_field(string what, int unsigned want, int unsigned got);
        if (want != got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch on %s: expected %0d, got %0d", what, want, got);
        end
    endfunction

    // Offer one sample, hold it until accepted, then predict its result
    task automatic send_sample(logic clr, logic ent, logic ext, logic [15:0] t);
        int gap;
        gap = send_gaps ? $urandom_range(0, 14) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_barrier_clear <= clr;
        i_entry_button <= ent;
        i_exit_button <= ext;
        i_time_ms <= t;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        last_time = t;
        pending_lights.push_back(step_controller(clr, ent, ext, t));
    endtask

    // Drop valid and wait until every transaction has come back
    task automatic drain_pipe();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_lights.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // APB write, then read back the same register
    task automatic write_register(logic [1:0] idx, logic [15:0] val);
        paddr <= ADDR_WIDTH'({idx, 2'b00});
        pwdata <= {16'h0000, val};
        pwrite <= 1'b1;
        psel <= 1'b1;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (idx)
            REG_OPERATE: operate_limit = val;
            REG_BARRIER: barrier_limit = val;
            REG_BLINK:   blink_period = val;
            default:     settle_time = val;
        endcase
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        check_field("register readback", val, prdata[15:0]);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_timing(logic [15:0] op, logic [15:0] bar, logic [15:0] blink,
                              logic [15:0] settle);
        drain_pipe();
        write_register(REG_OPERATE, op);
        write_register(REG_BARRIER, bar);
        write_register(REG_BLINK, blink);
        write_register(REG_SETTLE, settle);
    endtask

    // Mode-aware random traffic with boundary hits and some noise
    task automatic run_random(int count);
        logic        clr;
        logic        ent;
        logic        ext;
        logic [15:0] t;
        logic [15:0] base;
        int          lim;
        int          span;
        int          pick;
        for (int k = 0; k < count; k++) begin
            if (k % 40 == 0) begin
                send_gaps = ($urandom_range(0, 3) != 0);
                sink_stalls = ($urandom_range(0, 3) != 0);
            end
            ent = 1'($urandom_range(0, 1));
            ext = 1'($urandom_range(0, 1));
            case (ctl_mode)
                CODE_ENTRY, CODE_EXIT: begin
                    clr = ($urandom_range(0, 3) != 0);
                    lim = operate_limit;
                    base = 16'(operate_t0);
                end
                CODE_INTR: begin
                    clr = ($urandom_range(0, 2) == 0);
                    lim = $urandom_range(0, 1) ? barrier_limit : settle_time;
                    base = 16'(barrier_t0);
                end
                CODE_FAULT: begin
                    clr = ($urandom_range(0, 7) == 0);
                    lim = $urandom_range(0, 1) ? blink_period : (blink_period >> 1);
                    base = 16'(blink_t0);
                end
                default: begin
                    clr = 1'($urandom_range(0, 1));
                    ent = ($urandom_range(0, 2) == 0);
                    ext = ($urandom_range(0, 2) == 0);
                    lim = 64;
                    base = last_time;
                end
            endcase
            pick = $urandom_range(0, 19);
            span = lim + lim / 4 + 2;
            if (span > 65535) span = 65535;
            if (pick < 2) begin
                {clr, ent, ext} = 3'($urandom);
                t = 16'($urandom);
            end else if (pick < 5) begin
                t = base + 16'(lim) - 16'($urandom_range(0, 1));
            end else begin
                t = last_time + 16'($urandom_range(0, span));
            end
            send_sample(clr, ent, ext, t);
        end
    endtask

    // Walk every state and rule under the reset timing
    task automatic test_directed_sequences();
        logic [15:0] t;
        send_gaps = 1'b1;
        sink_stalls = 1'b1;
        send_sample(1'b1, 1'b0, 1'b0, 16'h0000);
        send_sample(1'b1, 1'b1, 1'b0, 16'd100);
        send_sample(1'b1, 1'b0, 1'b0, 16'd5099);
        send_sample(1'b1, 1'b0, 1'b0, 16'd5100);
        // both buttons, then a time that wraps past zero
        send_sample(1'b1, 1'b1, 1'b1, 16'hFFF0);
        send_sample(1'b1, 1'b0, 1'b0, 16'h1377);
        // broken beam at the timeout: interruption wins
        send_sample(1'b0, 1'b0, 1'b0, 16'h1378);
        send_sample(1'b1, 1'b0, 1'b0, 16'h1378);
        send_sample(1'b0, 1'b1, 1'b0, 16'h2000);
        t = 16'h2001;
        send_sample(1'b0, 1'b0, 1'b0, t);
        send_sample(1'b0, 1'b1, 1'b1, t + 16'd9999);
        t = t + 16'd10000;
        send_sample(1'b0, 1'b0, 1'b0, t);
        // fault blinking across half and full periods
        send_sample(1'b0, 1'b0, 1'b0, t + 16'd499);
        send_sample(1'b0, 1'b0, 1'b0, t + 16'd500);
        send_sample(1'b0, 1'b1, 1'b1, t + 16'd999);
        send_sample(1'b0, 1'b0, 1'b0, t + 16'd1000);
        send_sample(1'b0, 1'b0, 1'b0, t + 16'd1500);
        send_sample(1'b1, 1'b0, 1'b0, t + 16'd1600);
        send_sample(1'b1, 1'b0, 1'b1, 16'hFFFF);
        send_sample(1'b1, 1'b1, 1'b1, 16'h0000);
        send_sample(1'b1, 1'b0, 1'b0, 16'h8000);
        // restored beam at the barrier timeout: fault wins
        send_sample(1'b1, 1'b1, 1'b0, 16'h9000);
        send_sample(1'b0, 1'b0, 1'b0, 16'h9001);
        send_sample(1'b1, 1'b0, 1'b0, 16'h9001 + 16'd10000);
        send_sample(1'b1, 1'b0, 1'b0, 16'hA000);
    endtask

    task automatic test_reset_timing();
        run_random(300);
    endtask

    task automatic test_zero_timing();
        set_timing(16'd0, 16'd0, 16'd0, 16'd0);
        run_random(200);
    endtask

    task automatic test_max_timing();
        set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_random(200);
    endtask

    task automatic test_short_blink();
        set_timing(16'd200, 16'd800, 16'd1, 16'd50);
        run_random(120);
        set_timing(16'd40, 16'd90, 16'd2, 16'd0);
        run_random(120);
    endtask

    task automatic test_random_timing();
        repeat (3) begin
            set_timing(16'($urandom_range(1, 300)), 16'($urandom_range(1, 600)),
                       16'($urandom_range(2, 200)), 16'($urandom_range(0, 100)));
            run_random(250);
        end
        set_timing(16'hFFFF, 16'd0, 16'd2, 16'hFFFF);
        run_random(150);
    endtask

    // Hold the output long enough that the input side backs up
    task automatic test_output_backpressure();
        drain_pipe();
        send_gaps = 1'b0;
        sink_stalls = 1'b0;
        sink_hold_cycles = 300;
        for (int k = 0; k < 60; k++)
            send_sample(1'b1, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                        last_time + 16'($urandom_range(0, 3000)));
    endtask

    // Output side: draw a stall before each transaction
    initial begin
        int n;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (sink_hold_cycles > 0) begin
                n = sink_hold_cycles;
                sink_hold_cycles = 0;
            end else begin
                n = sink_stalls ? $urandom_range(0, 14) : 0;
            end
            if (n > 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
        end
    end

    // Compare each accepted result with the oldest prediction
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_lights.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result with no transaction outstanding, mode %0d", o_mode_now);
            end else begin
                want = pending_lights.pop_front();
                check_field("entry_red", want.lights.entry_red, o_entry_red);
                check_field("entry_green", want.lights.entry_green, o_entry_green);
                check_field("exit_red", want.lights.exit_red, o_exit_red);
                check_field("exit_green", want.lights.exit_green, o_exit_green);
                check_field("gate_light", want.lights.gate, o_gate_light);
                check_field("mode_now", want.mode_now, o_mode_now);
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    initial begin
        int stuck;
        stuck = 0;
        while (stuck < STUCK_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (psel && penable && pready))
                stuck = 0;
            else
                stuck++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_sequences();
        test_reset_timing();
        test_zero_timing();
        test_max_timing();
        test_short_blink();
        test_random_timing();
        test_output_backpressure();
        drain_pipe();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

`default_nettype wire
